@@ sv/lpse_pkg.sv @@
`default_nettype none

package lpse_pkg;

  // sensor row
  localparam int NSENS = 6;
  localparam int NSEG  = 4;

  // widths: calibrated reading, curve coefficient, level, quotient bits
  localparam int RW = 18;
  localparam int CW = 26;
  localparam int LW = 26;
  localparam int QW = 25;

  // calibration: x = 1280*|s - offset| + span/64, reading = x / (span/32)
  localparam int XW       = 27;
  localparam int RSH      = 27;
  localparam int CAL_GAIN = 1280;
  localparam int CAL_LAT  = 4;

  typedef logic signed [RW-1:0] rdg_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [LW-1:0] lvl_t;

  localparam logic [15:0] CAL_OFFSET [NSENS] = '{
    16'd18944, 16'd14272, 16'd15424, 16'd13376, 16'd8192, 16'd5632
  };

  localparam logic [9:0] CAL_HALF [NSENS] = '{
    10'(44224 / 64), 10'(48896 / 64), 10'(47808 / 64),
    10'(49856 / 64), 10'(54656 / 64), 10'(47936 / 64)
  };

  localparam logic [10:0] CAL_DEN [NSENS] = '{
    11'(44224 / 32), 11'(48896 / 32), 11'(47808 / 32),
    11'(49856 / 32), 11'(54656 / 32), 11'(47936 / 32)
  };

  localparam logic [16:0] CAL_RECIP [NSENS] = '{
    17'((1 << RSH) / (44224 / 32)), 17'((1 << RSH) / (48896 / 32)),
    17'((1 << RSH) / (47808 / 32)), 17'((1 << RSH) / (49856 / 32)),
    17'((1 << RSH) / (54656 / 32)), 17'((1 << RSH) / (47936 / 32))
  };

  localparam lvl_t LVL_HI = LW'(262143);
  localparam lvl_t LVL_LO = -LW'(262144);

  // one later segment as seen by its selection cell
  typedef struct packed {
    logic vld;
    lvl_t vlvl;
    rdg_t rl;
    rdg_t rr;
  } seg_in_t;

endpackage

`default_nettype wire

@@ sv/lpse_cal.sv @@
`default_nettype none

module lpse_cal import lpse_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] sample,
  output rdg_t        rdg
);

  logic [16:0]   diff;
  logic [16:0]   mag;
  logic [XW-1:0] x1, x2, x3;
  logic          neg1, neg2, neg3;
  logic [XW+16:0] prod2;
  logic [16:0]   q0;
  logic [16:0]   q3;
  logic [XW:0]   t3;
  logic [XW-1:0] rem;
  logic [16:0]   q;
  rdg_t          qs;

  // offset removal and magnitude
  assign diff = {1'b0, sample} - {1'b0, CAL_OFFSET[LANE]};
  assign mag  = diff[16] ? (17'd0 - diff) : diff;

  // reciprocal estimate, then one correction step
  assign q0  = prod2[XW+16:RSH];
  assign rem = x3 - t3[XW-1:0];
  assign q   = q3 + {16'd0, (rem >= XW'(CAL_DEN[LANE]))};
  assign qs  = RW'(q);

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= XW'(mag * CAL_GAIN) + XW'(CAL_HALF[LANE]);
      neg1  <= diff[16];
      prod2 <= x1 * CAL_RECIP[LANE];
      x2    <= x1;
      neg2  <= neg1;
      t3    <= q0 * CAL_DEN[LANE];
      q3    <= q0;
      x3    <= x2;
      neg3  <= neg2;
      rdg   <= neg3 ? -qs : qs;
    end
  end

endmodule

`default_nettype wire

@@ sv/lpse_div.sv @@
`default_nettype none

module lpse_div import lpse_pkg::*; #(
  parameter int NW = 34,
  parameter int DW = 28
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [1:QW-1];
  logic [QW-1:0] low_r [1:QW-1];
  logic [DW-1:0] dvs_r [1:QW-1];
  logic [QW-1:0] quo_r [1:QW];

  // one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_head
      assign rem_in = DW'(num >> QW);
      assign low_in = num[QW-1:0];
      assign dvs_in = den;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_r[i];
      assign low_in = low_r[i];
      assign dvs_in = dvs_r[i];
      assign quo_in = quo_r[i];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i+1] <= {quo_in[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          low_r[i+1] <= {low_in[QW-2:0], 1'b0};
          dvs_r[i+1] <= dvs_in;
        end
      end
    end
  end

  assign quo = quo_r[QW];

endmodule

`default_nettype wire

@@ sv/lpse_seg.sv @@
`default_nettype none

module lpse_seg import lpse_pkg::*; #(
  parameter int PW = 11
) (
  input  logic                 clk,
  input  logic                 en,
  input  seg_in_t              cin,
  input  logic signed [PW-1:0] vpos,
  input  logic signed [PW-1:0] spl,
  input  logic signed [PW-1:0] spr,
  input  logic signed [PW-1:0] pos_in,
  input  lvl_t                 lvl_in,
  output logic signed [PW-1:0] pos_out,
  output lvl_t                 lvl_out
);

  lvl_t rl_x, rr_x;

  assign rl_x = LW'(cin.rl);
  assign rr_x = LW'(cin.rr);

  // take vertex if lower, else a lower end, else hold the running minimum
  always_ff @(posedge clk) begin
    if (en) begin
      if (cin.vld && (lvl_in > cin.vlvl)) begin
        pos_out <= vpos;
        lvl_out <= cin.vlvl;
      end else if ((lvl_in > rl_x) || (lvl_in > rr_x)) begin
        if (rl_x < rr_x) begin
          pos_out <= spl;
          lvl_out <= rl_x;
        end else begin
          pos_out <= spr;
          lvl_out <= rr_x;
        end
      end else begin
        pos_out <= pos_in;
        lvl_out <= lvl_in;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/line_position_spline_estimator.sv @@
`default_nettype none

// Stages from an accepted sample beat to its result beat: 4 calibration, 5 curve setup,
//   25 divider stages, 1 candidate, 3 selection cells, 1 output register.
// Throughput: one sample beat per cycle; the pipeline holds while a result and a
//   skid entry both wait, and sample_stall is the skid-full flag.
// Reset clears the valid pipeline and the output and skid flags; data registers are not reset.
module line_position_spline_estimator import lpse_pkg::*; #(
  parameter int POSITION_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [15:0]        sample_0,
  input  logic [15:0]        sample_1,
  input  logic [15:0]        sample_2,
  input  logic [15:0]        sample_3,
  input  logic [15:0]        sample_4,
  input  logic [15:0]        sample_5,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [10:0] line_position,
  output logic signed [18:0] min_level
);

  localparam int P    = POSITION_FRAC_BITS;
  localparam int PW   = P + 3;
  localparam int PNW  = CW + P + 2;
  localparam int PDW  = CW + 2;
  localparam int LNW  = 2 * CW + 2;
  localparam int LDW  = CW + 4;
  localparam int NSTG = CAL_LAT + 5 + QW + 1 + (NSEG - 1);
  localparam int RDLY = 5 + QW;
  localparam int FDLY = 2 + QW;
  localparam logic signed [PW-1:0] POS_LIM = PW'(5 * (1 << (P - 1)));

  function automatic logic signed [PW-1:0] spos(input int k);
    return PW'((2 * k - 5) * (1 << (P - 1)));
  endfunction

  logic            en;
  logic [NSTG:1]   vpipe;
  logic            skid_v;
  logic [10:0]     skid_pos;
  logic [18:0]     skid_lvl;

  assign en           = !skid_v;
  assign sample_stall = skid_v;

  // calibration lanes
  logic [15:0] smp [NSENS];
  rdg_t        rc  [NSENS];

  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;
  assign smp[4] = sample_4;
  assign smp[5] = sample_5;

  for (genvar k = 0; k < NSENS; k++) begin : g_cal
    lpse_cal #(.LANE(k)) u_cal (
      .clk    (clk),
      .en     (en),
      .sample (smp[k]),
      .rdg    (rc[k])
    );
  end

  // first stage: first quadratic and interval differences
  coef_t a2_1, b2_1, d2_1;
  coef_t qd_1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a2_1 <= CW'(rc[0]) - (CW'(rc[1]) <<< 1) + CW'(rc[2]);
      b2_1 <= CW'(rc[2]) - CW'(rc[0]);
      d2_1 <= CW'(rc[0]) - (CW'(rc[1]) <<< 2) + (CW'(rc[2]) <<< 1) + CW'(rc[2]);
      for (int k = 0; k < 3; k++) begin
        qd_1[k] <= CW'(rc[k+3]) - CW'(rc[k+2]);
      end
    end
  end

  // second stage: slope numerator m and curvature c of each segment
  coef_t m_2 [NSEG];
  coef_t c_2 [NSEG];

  always_ff @(posedge clk) begin
    if (en) begin
      m_2[0] <= -b2_1;
      c_2[0] <= a2_1;
      m_2[1] <= -d2_1;
      c_2[1] <= (qd_1[0] <<< 1) - d2_1;
      m_2[2] <= d2_1 - (qd_1[0] <<< 2);
      c_2[2] <= (qd_1[1] <<< 1) - (qd_1[0] <<< 2) + d2_1;
      m_2[3] <= (qd_1[0] <<< 2) - (qd_1[1] <<< 2) - d2_1;
      c_2[3] <= (qd_1[2] <<< 1) - (qd_1[1] <<< 2) + (qd_1[0] <<< 2) - d2_1;
    end
  end

  // third stage: magnitudes, signs, vertex range check
  logic [CW-1:0]   am_3 [NSEG];
  logic [CW-1:0]   ac_3 [NSEG];
  logic [NSEG-1:0] vld_3, psg_3, lsg_3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSEG; s++) begin
        logic [CW-1:0] am, ac;
        logic          sm, sc, inr;
        sm  = m_2[s][CW-1];
        sc  = c_2[s][CW-1];
        am  = sm ? CW'(-m_2[s]) : CW'(m_2[s]);
        ac  = sc ? CW'(-c_2[s]) : CW'(c_2[s]);
        inr = ({1'b0, am} <= {ac, 1'b0}) && (ac != '0);
        am_3[s]  <= am;
        ac_3[s]  <= ac;
        psg_3[s] <= sm ^ sc;
        lsg_3[s] <= sc;
        if (s == 0) begin
          vld_3[s] <= inr;
        end else begin
          vld_3[s] <= inr && ((am == '0) || (sm == sc));
        end
      end
    end
  end

  // fourth stage: square and position numerator
  logic [2*CW-1:0] sq_4 [NSEG];
  logic [PNW-1:0]  pn_4 [NSEG];
  logic [CW-1:0]   ac_4 [NSEG];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSEG; s++) begin
        sq_4[s] <= am_3[s] * am_3[s];
        pn_4[s] <= PNW'({am_3[s], {(P + 1){1'b0}}}) + PNW'({ac_3[s], 1'b0});
        ac_4[s] <= ac_3[s];
      end
    end
  end

  // fifth stage: divider operands
  logic [LNW-1:0] ln_5 [NSEG];
  logic [LDW-1:0] ld_5 [NSEG];
  logic [PNW-1:0] pn_5 [NSEG];
  logic [PDW-1:0] pd_5 [NSEG];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSEG; s++) begin
        ln_5[s] <= LNW'({sq_4[s], 1'b0}) + LNW'({ac_4[s], 3'b000});
        ld_5[s] <= {ac_4[s], 4'b0000};
        pn_5[s] <= pn_4[s];
        pd_5[s] <= {ac_4[s], 2'b00};
      end
    end
  end

  // vertex offset and vertex depth dividers
  logic [QW-1:0] pq [NSEG];
  logic [QW-1:0] lq [NSEG];

  for (genvar s = 0; s < NSEG; s++) begin : g_div
    lpse_div #(.NW(PNW), .DW(PDW)) u_pdiv (
      .clk (clk),
      .en  (en),
      .num (pn_5[s]),
      .den (pd_5[s]),
      .quo (pq[s])
    );
    lpse_div #(.NW(LNW), .DW(LDW)) u_ldiv (
      .clk (clk),
      .en  (en),
      .num (ln_5[s]),
      .den (ld_5[s]),
      .quo (lq[s])
    );
  end

  // delay readings and flags alongside the dividers
  logic [NSENS-1:0][RW-1:0] rline [1:RDLY];
  logic [3*NSEG-1:0]        fline [1:FDLY];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSENS; k++) begin
        rline[1][k] <= rc[k];
      end
      for (int i = 2; i <= RDLY; i++) begin
        rline[i] <= rline[i-1];
      end
      fline[1] <= {vld_3, psg_3, lsg_3};
      for (int i = 2; i <= FDLY; i++) begin
        fline[i] <= fline[i-1];
      end
    end
  end

  // candidate stage: vertices, and the first segment's pick
  rdg_t                 rd [NSENS];
  logic [NSEG-1:0]      vld_d, psg_d, lsg_d;
  logic signed [PW-1:0] vpos [NSEG];
  lvl_t                 vlvl [NSEG];

  assign {vld_d, psg_d, lsg_d} = fline[FDLY];

  for (genvar k = 0; k < NSENS; k++) begin : g_rd
    assign rd[k] = rdg_t'(rline[RDLY][k]);
  end

  for (genvar s = 0; s < NSEG; s++) begin : g_vtx
    logic signed [PW-1:0] pqs;
    lvl_t                 lqs;
    assign pqs     = PW'(pq[s]);
    assign lqs     = LW'(lq[s]);
    assign vpos[s] = spos(s + 1) + (psg_d[s] ? -pqs : pqs);
    assign vlvl[s] = LW'(rd[s+1]) - (lsg_d[s] ? -lqs : lqs);
  end

  logic signed [PW-1:0] pos_c;
  lvl_t                 lvl_c;
  seg_in_t              cnd_c [NSEG-1];
  logic signed [PW-1:0] vp_c  [NSEG-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (vld_d[0]) begin
        pos_c <= vpos[0];
        lvl_c <= vlvl[0];
      end else if (rd[0] < rd[2]) begin
        pos_c <= spos(0);
        lvl_c <= LW'(rd[0]);
      end else begin
        pos_c <= spos(2);
        lvl_c <= LW'(rd[2]);
      end
      for (int j = 0; j < NSEG - 1; j++) begin
        cnd_c[j].vld  <= vld_d[j+1];
        cnd_c[j].vlvl <= vlvl[j+1];
        cnd_c[j].rl   <= rd[j+2];
        cnd_c[j].rr   <= rd[j+3];
        vp_c[j]       <= vpos[j+1];
      end
    end
  end

  // selection cells for the later segments
  logic signed [PW-1:0] pos_k [NSEG];
  lvl_t                 lvl_k [NSEG];

  assign pos_k[0] = pos_c;
  assign lvl_k[0] = lvl_c;

  for (genvar j = 0; j < NSEG - 1; j++) begin : g_cell
    seg_in_t              cin;
    logic signed [PW-1:0] vpi;

    if (j == 0) begin : g_now
      assign cin = cnd_c[0];
      assign vpi = vp_c[0];
    end else begin : g_dly
      seg_in_t              cq [j];
      logic signed [PW-1:0] vq [j];
      always_ff @(posedge clk) begin
        if (en) begin
          cq[0] <= cnd_c[j];
          vq[0] <= vp_c[j];
          for (int t = 1; t < j; t++) begin
            cq[t] <= cq[t-1];
            vq[t] <= vq[t-1];
          end
        end
      end
      assign cin = cq[j-1];
      assign vpi = vq[j-1];
    end

    lpse_seg #(.PW(PW)) u_seg (
      .clk     (clk),
      .en      (en),
      .cin     (cin),
      .vpos    (vpi),
      .spl     (spos(j + 2)),
      .spr     (spos(j + 3)),
      .pos_in  (pos_k[j]),
      .lvl_in  (lvl_k[j]),
      .pos_out (pos_k[j+1]),
      .lvl_out (lvl_k[j+1])
    );
  end

  // saturate the final pick
  logic signed [PW-1:0] pos_sat;
  lvl_t                 lvl_sat;
  logic [10:0]          pos_o;
  logic [18:0]          lvl_o;

  always_comb begin
    if (pos_k[NSEG-1] > POS_LIM) begin
      pos_sat = POS_LIM;
    end else if (pos_k[NSEG-1] < -POS_LIM) begin
      pos_sat = -POS_LIM;
    end else begin
      pos_sat = pos_k[NSEG-1];
    end
    if (lvl_k[NSEG-1] > LVL_HI) begin
      lvl_sat = LVL_HI;
    end else if (lvl_k[NSEG-1] < LVL_LO) begin
      lvl_sat = LVL_LO;
    end else begin
      lvl_sat = lvl_k[NSEG-1];
    end
  end

  assign pos_o = 11'(pos_sat);
  assign lvl_o = 19'(lvl_sat);

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[NSTG-1:1], sample_valid};
    end
  end

  // output register with one skid entry
  logic pop;
  logic incoming;

  assign pop      = result_valid && !result_stall;
  assign incoming = en && vpipe[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        line_position <= skid_pos;
        min_level     <= skid_lvl;
        skid_v        <= 1'b0;
      end
    end else if (incoming) begin
      if (!result_valid || pop) begin
        line_position <= pos_o;
        min_level     <= lvl_o;
        result_valid  <= 1'b1;
      end else begin
        skid_pos <= pos_o;
        skid_lvl <= lvl_o;
        skid_v   <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid entry held without a result beat in the output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid && result_stall))
    else $error("skid entry filled while the output register was free");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (incoming && result_valid && result_stall) |=> skid_v)
    else $error("arriving beat dropped while the output was stalled");

endmodule

`default_nettype wire
